FILE: rtl/dlstq_pkg.sv
// Shared types and codes for the delta-list sleep timer queue.
package dlstq_pkg;

  localparam int ID_W    = 4;
  localparam int DELAY_W = 31;
  localparam int ENTRY_W = ID_W + DELAY_W;

  typedef enum logic [0:0] {
    OP_SLEEP = 1'b0,
    OP_TICK  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_TICK    = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [0:0]         opcode;
    logic [ID_W-1:0]    thread_id;
    logic [DELAY_W-1:0] delay_ticks;
  } req_item_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [1:0]      status;
    logic [ID_W-1:0] released_thread;
    logic            last;
  } rsp_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_in;
    logic    rd_pos;
    logic    walk_step;
    logic    set_idx;
    logic    rd_shift;
    logic    wr_shift;
    logic    wr_new;
    logic    rd_head;
    logic    wr_head_dec;
    logic    pop;
    logic    emit;
    kind_t   emit_kind;
    status_t emit_status;
    logic    emit_last;
    logic    emit_rel;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tick;
    logic delay_zero;
    logic full;
    logic empty;
    logic pos_end;
    logic rem_ge;
    logic idx_gt_pos;
    logic rd_le_one;
    logic rd_zero;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: rtl/dlstq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dlstq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/dlstq_ctrl.sv
// Controller state machine for the delta-list sleep timer queue.
module dlstq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  dlstq_pkg::dp_sts_t sts,
  output dlstq_pkg::dp_cmd_t cmd
);

  import dlstq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_WALK_RD,
    S_WALK_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_ACK_OK,
    S_ACK_FULL,
    S_TICK_EMPTY,
    S_TICK_RD,
    S_TICK_CHK,
    S_TICK_NONE,
    S_REL_RD,
    S_REL_CHK,
    S_REL_MORE
  } state_t;

  state_t state, state_next;

  // Set when the pending release is the final result of the tick.
  logic rel_last, rel_last_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rel_last <= 1'b0;
    end else begin
      state    <= state_next;
      rel_last <= rel_last_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    rel_last_next = rel_last;
    cmd           = '0;
    cmd.emit_kind   = KIND_ACK;
    cmd.emit_status = STATUS_OK;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_tick) begin
          state_next = sts.empty ? S_TICK_EMPTY : S_TICK_RD;
        end else if (sts.delay_zero) begin
          state_next = S_ACK_OK;
        end else if (sts.full) begin
          state_next = S_ACK_FULL;
        end else begin
          state_next = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        if (sts.pos_end) begin
          state_next = S_INSERT;
        end else begin
          cmd.rd_pos = 1'b1;
          state_next = S_WALK_CMP;
        end
      end
      S_WALK_CMP: begin
        if (sts.rem_ge) begin
          cmd.walk_step = 1'b1;
          state_next    = S_WALK_RD;
        end else begin
          cmd.set_idx = 1'b1;
          state_next  = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        if (sts.idx_gt_pos) begin
          cmd.rd_shift = 1'b1;
          state_next   = S_SHIFT_WR;
        end else begin
          state_next = S_INSERT;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        state_next   = S_SHIFT_RD;
      end
      S_INSERT: begin
        cmd.wr_new = 1'b1;
        state_next = S_ACK_OK;
      end
      S_ACK_OK, S_ACK_FULL, S_TICK_EMPTY, S_TICK_NONE: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
        case (state)
          S_ACK_FULL:   cmd.emit_status = STATUS_FULL;
          S_TICK_EMPTY: begin
            cmd.emit_kind   = KIND_TICK;
            cmd.emit_status = STATUS_EMPTY;
          end
          S_TICK_NONE:  cmd.emit_kind = KIND_TICK;
          default:      cmd.emit_kind = KIND_ACK;
        endcase
      end
      S_TICK_RD: begin
        cmd.rd_head = 1'b1;
        state_next  = S_TICK_CHK;
      end
      S_TICK_CHK: begin
        if (sts.rd_le_one) begin
          // Head expires on this tick: hold its id and drop it from the list.
          cmd.pop    = 1'b1;
          state_next = S_REL_RD;
        end else begin
          cmd.wr_head_dec = 1'b1;
          state_next      = S_TICK_NONE;
        end
      end
      S_REL_RD: begin
        if (sts.empty) begin
          rel_last_next = 1'b1;
          state_next    = S_REL_MORE;
        end else begin
          cmd.rd_head = 1'b1;
          state_next  = S_REL_CHK;
        end
      end
      S_REL_CHK: begin
        rel_last_next = !sts.rd_zero;
        state_next    = S_REL_MORE;
      end
      S_REL_MORE: begin
        cmd.emit_kind = KIND_RELEASE;
        cmd.emit_rel  = 1'b1;
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = rel_last;
          if (rel_last) begin
            state_next = S_IDLE;
          end else begin
            // Next head is also due: take it as the pending release.
            cmd.pop    = 1'b1;
            state_next = S_REL_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/dlstq_dp.sv
// Datapath: ring-buffer delta list, walk arithmetic and result register.
module dlstq_dp #(
  parameter int MAX_SLEEPERS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dlstq_pkg::req_item_t  req,
  input  dlstq_pkg::dp_cmd_t    cmd,
  output dlstq_pkg::dp_sts_t    sts,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output dlstq_pkg::rsp_item_t  rsp
);

  import dlstq_pkg::*;

  localparam int AW = $clog2(MAX_SLEEPERS);
  localparam int CW = $clog2(MAX_SLEEPERS + 1);
  localparam logic [AW:0]   DEPTH_A = (AW+1)'(MAX_SLEEPERS);
  localparam logic [CW-1:0] DEPTH_C = CW'(MAX_SLEEPERS);
  localparam logic [AW-1:0] LAST_A  = AW'(MAX_SLEEPERS - 1);

  // Control state
  logic [AW-1:0] head;
  logic [CW-1:0] count;

  // Per-item working registers
  logic               is_tick;
  logic [ID_W-1:0]    tid;
  logic [DELAY_W-1:0] rem;
  logic [CW-1:0]      pos;
  logic [CW-1:0]      idx;
  logic [ID_W-1:0]    pend_id;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [ID_W-1:0]    rd_id;
  logic [DELAY_W-1:0] rd_delta;
  logic [CW-1:0]      idx_m1;

  // Map a list position onto a ring address.
  function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                              input logic [CW-1:0] ofs);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, ofs[AW-1:0]};
    if (sum >= DEPTH_A) begin
      sum = sum - DEPTH_A;
    end
    return sum[AW-1:0];
  endfunction

  assign rd_id    = ram_rdata[ENTRY_W-1 -: ID_W];
  assign rd_delta = ram_rdata[DELAY_W-1:0];
  assign idx_m1   = idx - CW'(1);

  always_comb begin
    ram_re    = cmd.rd_pos | cmd.rd_shift | cmd.rd_head;
    ram_raddr = head;
    if (cmd.rd_pos) begin
      ram_raddr = ring_addr(head, pos);
    end else if (cmd.rd_shift) begin
      ram_raddr = ring_addr(head, idx_m1);
    end

    ram_we    = cmd.wr_shift | cmd.wr_new | cmd.wr_head_dec;
    ram_waddr = head;
    ram_wdata = {rd_id, rd_delta - DELAY_W'(1)};
    if (cmd.wr_shift) begin
      ram_waddr = ring_addr(head, idx);
      // The entry that ends up after the new one loses the remainder.
      ram_wdata = {rd_id, (idx_m1 == pos) ? (rd_delta - rem) : rd_delta};
    end else if (cmd.wr_new) begin
      ram_waddr = ring_addr(head, pos);
      ram_wdata = {tid, rem};
    end
  end

  dlstq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SLEEPERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.wr_new) begin
        count <= count + CW'(1);
      end else if (cmd.pop) begin
        count <= count - CW'(1);
        head  <= (head == LAST_A) ? '0 : head + AW'(1);
      end
      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      is_tick <= (req.opcode == OP_TICK);
      tid     <= req.thread_id;
      rem     <= req.delay_ticks;
      pos     <= '0;
    end else if (cmd.walk_step) begin
      rem <= rem - rd_delta;
      pos <= pos + CW'(1);
    end
    if (cmd.set_idx) begin
      idx <= count;
    end else if (cmd.wr_shift) begin
      idx <= idx_m1;
    end
    if (cmd.pop) begin
      pend_id <= rd_id;
    end
    if (cmd.emit) begin
      rsp.kind            <= cmd.emit_kind;
      rsp.status          <= cmd.emit_status;
      rsp.released_thread <= cmd.emit_rel ? pend_id : '0;
      rsp.last            <= cmd.emit_last;
    end
  end

  always_comb begin
    sts.is_tick    = is_tick;
    sts.delay_zero = (rem == '0);
    sts.full       = (count == DEPTH_C);
    sts.empty      = (count == '0);
    sts.pos_end    = (pos == count);
    sts.rem_ge     = (rem >= rd_delta);
    sts.idx_gt_pos = (idx > pos);
    sts.rd_le_one  = (rd_delta[DELAY_W-1:1] == '0);
    sts.rd_zero    = (rd_delta == '0);
    sts.out_free   = !rsp_valid || rsp_ready;
  end

endmodule

FILE: rtl/delta_list_sleep_timer_queue_core.sv
// Top level of the delta-list sleep timer queue: controller plus datapath.
//
//   channel | signals                    | dir | carries
//   --------+----------------------------+-----+-------------------------------------
//   req     | req_valid, req_ready, req  | in  | sleep request or timer tick item
//   rsp     | rsp_valid, rsp_ready, rsp  | out | acknowledge, tick status, releases
//
// Sequence of work: a sleep item reads each entry it walks past, then moves the
//   later entries back one place, reading each and writing it one slot further on;
//   both pass through the single read port of the list RAM. A tick reads the head
//   and decrements it, or releases it and each next head that is due with it;
//   a zero delay, a full list or an empty tick is answered without touching the list.
// Reset clears the list length, ring head and result valid; list storage is not
//   cleared, since only entries below the length are ever read.
// A pending result sits in its own register, so the next item is taken while it
//   waits; a stalled rsp only holds the controller when a further result is due.
module delta_list_sleep_timer_queue_core #(
  parameter int MAX_SLEEPERS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  dlstq_pkg::req_item_t req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output dlstq_pkg::rsp_item_t rsp
);

  import dlstq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequence each item: walk, shift, insert, or decrement and release.
  dlstq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold the list in a ring buffer and the result item in its register.
  dlstq_dp #(
    .MAX_SLEEPERS (MAX_SLEEPERS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the delta-list sleep timer queue core.
`timescale 1ns / 100ps

module tb;
  import dlstq_pkg::*;

  localparam int DEPTH     = 16;
  localparam int LIMIT     = 200000;
  localparam int RAND_ITEMS = 75;
  localparam logic [DELAY_W-1:0] DELAY_MAX = {DELAY_W{1'b1}};

  // Shadow of the sleeper list: works out which results every accepted item is due to
  // produce, and checks the block's results against them in order.
  class sleep_list_board;
    logic [ID_W-1:0]    slot_id[DEPTH];
    logic [DELAY_W-1:0] slot_gap[DEPTH];
    int                 live_count;
    rsp_item_t          due_rsp[$];
    int                 mismatches;

    function new();
      live_count = 0;
      mismatches = 0;
    endfunction

    function void push_due(kind_t k, status_t s, logic [ID_W-1:0] id, logic fin);
      rsp_item_t r;
      r.kind            = k;
      r.status          = s;
      r.released_thread = id;
      r.last            = fin;
      due_rsp.push_back(r);
    endfunction

    function void note_request(req_item_t it);
      logic [DELAY_W-1:0] left;
      int pos;
      int n;
      left = it.delay_ticks;
      if (it.opcode == OP_SLEEP) begin
        if (left == '0) begin
          // zero delay: acknowledge only, even on a full list
          push_due(KIND_ACK, STATUS_OK, '0, 1'b1);
        end else if (live_count >= DEPTH) begin
          push_due(KIND_ACK, STATUS_FULL, '0, 1'b1);
        end else begin
          // walk past every entry expiring no later than the new one
          pos = 0;
          while (pos < live_count && left >= slot_gap[pos]) begin
            left = left - slot_gap[pos];
            pos++;
          end
          if (pos < live_count) slot_gap[pos] = slot_gap[pos] - left;
          for (int i = live_count; i > pos; i--) begin
            slot_id[i]  = slot_id[i-1];
            slot_gap[i] = slot_gap[i-1];
          end
          slot_id[pos]  = it.thread_id;
          slot_gap[pos] = left;
          live_count++;
          push_due(KIND_ACK, STATUS_OK, '0, 1'b1);
        end
      end else if (live_count == 0) begin
        push_due(KIND_TICK, STATUS_EMPTY, '0, 1'b1);
      end else begin
        if (slot_gap[0] != '0) slot_gap[0] = slot_gap[0] - 1'b1;
        n = 0;
        while (n < live_count && slot_gap[n] == '0) begin
          push_due(KIND_RELEASE, STATUS_OK, slot_id[n],
                   (n + 1 >= live_count) || (slot_gap[n+1] != '0));
          n++;
        end
        if (n == 0) begin
          push_due(KIND_TICK, STATUS_OK, '0, 1'b1);
        end else begin
          for (int i = n; i < live_count; i++) begin
            slot_id[i-n]  = slot_id[i];
            slot_gap[i-n] = slot_gap[i];
          end
          live_count = live_count - n;
        end
      end
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 40) $display("%0t mismatch: %s", $time, what);
    endtask

    task check_response(rsp_item_t got);
      rsp_item_t want;
      if (due_rsp.size() == 0) begin
        report($sformatf("unasked result kind %0d status %0d thread %0d last %0d",
                         got.kind, got.status, got.released_thread, got.last));
      end else begin
        want = due_rsp.pop_front();
        if (got.kind !== want.kind)
          report($sformatf("kind %0d, want %0d", got.kind, want.kind));
        if (got.status !== want.status)
          report($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.released_thread !== want.released_thread)
          report($sformatf("released_thread %0d, want %0d",
                           got.released_thread, want.released_thread));
        if (got.last !== want.last)
          report($sformatf("last %0d, want %0d", got.last, want.last));
      end
    endtask
  endclass

  logic      clk;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_item_t req       = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_item_t rsp;

  sleep_list_board board = new();
  bit  calm   = 1'b0;   // set for the closing stretch: no idling on either side
  int  cycles = 0;

  delta_list_sleep_timer_queue_core #(
    .MAX_SLEEPERS(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abandon the run if it overstays the worst correct case by a wide margin.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stall the result side in bursts of random length, leaving long open stretches too.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Sample at the edge, before the block's registers move: compare each result taken.
  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_ready) board.check_response(rsp);
  end

  // Offer one item, maybe after an idle burst, and hold it until the block takes it.
  task automatic send_item(input req_item_t it);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req       <= it;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    board.note_request(it);
  endtask

  task automatic sleep_req(input logic [ID_W-1:0] id, input logic [DELAY_W-1:0] ticks);
    req_item_t it;
    it.opcode      = OP_SLEEP;
    it.thread_id   = id;
    it.delay_ticks = ticks;
    send_item(it);
  endtask

  task automatic tick_req();
    req_item_t it;
    it.opcode      = OP_TICK;
    it.thread_id   = 4'($urandom());
    it.delay_ticks = DELAY_W'($urandom());
    send_item(it);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty tick, zero delay, the longest delay stored for good,
    // equal expiries kept in arrival order, a tick with nothing due, then fill
    // the list, knock on it while full and release a crowd in one tick.
    tick_req();
    sleep_req(4'd3, '0);
    sleep_req(4'd15, DELAY_MAX);
    sleep_req(4'd5, 31'd2);
    sleep_req(4'd6, 31'd2);
    sleep_req(4'd0, 31'd1);
    tick_req();
    tick_req();
    tick_req();
    for (int i = 0; i < DEPTH - 1; i++) sleep_req(4'(i), (i < 10) ? 31'd1 : 31'(i - 8));
    sleep_req(4'd9, DELAY_MAX);
    sleep_req(4'd10, '0);
    tick_req();

    // Random part: a mix of sleeps and ticks that keeps the list busy and fills it
    // now and then; only a full list sees wide delays, so nothing else sticks.
    for (int i = 0; i < RAND_ITEMS; i++) begin
      calm = (i >= RAND_ITEMS - 25);
      if (board.live_count >= DEPTH) begin
        if ($urandom_range(0, 1) == 0) tick_req();
        else sleep_req(4'($urandom()), ($urandom_range(0, 5) == 0) ? '0 : DELAY_W'($urandom()));
      end else if ($urandom_range(0, 9) < 4) begin
        tick_req();
      end else begin
        case ($urandom_range(0, 9))
          0:       sleep_req(4'($urandom()), '0);
          1:       sleep_req(4'($urandom()), 31'($urandom_range(11, 40)));
          default: sleep_req(4'($urandom()), 31'($urandom_range(1, 10)));
        endcase
      end
    end
    req_valid <= 1'b0;

    // Drain: wait for every due result, then give the block a little longer.
    while (board.due_rsp.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (board.mismatches == 0 && board.due_rsp.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/dlstq_pkg.sv
rtl/dlstq_ram.sv
rtl/dlstq_ctrl.sv
rtl/dlstq_dp.sv
rtl/delta_list_sleep_timer_queue_core.sv
tb/tb.sv
